### sv/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Shared widths, register indexes and reset values of the stereo point unit.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FOCAL_W        = 16;
    localparam int BASE_W         = 20;
    localparam int GOOD_W         = 31;
    localparam int LIMIT_W        = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 31;
    localparam int SPAN_W         = GOOD_W + 4;
    localparam int TNUM_W         = LIMIT_W + SPAN_W;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_CY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOOD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd6;

    localparam logic [GOOD_W-1:0]  GOOD_RESET  = 31'd10000000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd512;
    localparam logic [LIMIT_W-1:0] ONE_PIXEL   = 16'd256;

endpackage

### sv/stereo_triangulate_point_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_triangulate_point_unit
// Stereo triangulation of one left/right match into X, Y, Z with near flag
// and a depth-dependent squared inlier threshold.
// ----------------------------------------------------------------------------
// A match is taken on every cycle with start high; busy never rises. Each
// beat comes out on o_strobe for one cycle, in order. The path runs through
// two chains of restoring divider stages, one quotient bit per stage: X, Y
// and Z in parallel, then the inlier threshold. The divider widths follow
// NUM_W = max(COORD_BITS, 16) + 21. The output cannot be held off.
module stereo_triangulate_point_unit #(
    parameter int COORD_BITS = stp_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [COORD_BITS-1:0]            i_left_x,
    input  logic [COORD_BITS-1:0]            i_left_y,
    input  logic [COORD_BITS-1:0]            i_right_x,
    input  logic                             i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_strobe,
    output logic signed [31:0]               o_point_x,
    output logic signed [31:0]               o_point_y,
    output logic [30:0]                      o_point_z,
    output logic                             o_near_point,
    output logic [31:0]                      o_limit_squared,
    output logic                             o_flipped
);

    localparam int W      = COORD_BITS;
    localparam int MAG_W  = (W > stp_pkg::FOCAL_W) ? W : stp_pkg::FOCAL_W;
    localparam int PROD_W = MAG_W + stp_pkg::BASE_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int Z10_W  = NUM_W + 4;
    localparam int SPAN_W = stp_pkg::SPAN_W;
    localparam int TSB_W  = 32 + 32 + 31 + 3;

    // configuration
    logic [W-1:0]                    r_lcx, r_lcy, r_rcx;
    logic [stp_pkg::FOCAL_W-1:0]     r_focal;
    logic [stp_pkg::BASE_W-1:0]      r_base;
    logic [stp_pkg::GOOD_W-1:0]      r_good;
    logic [stp_pkg::LIMIT_W-1:0]     r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcx   <= '0;
            r_lcy   <= '0;
            r_rcx   <= '0;
            r_focal <= '0;
            r_base  <= '0;
            r_good  <= stp_pkg::GOOD_RESET;
            r_limit <= stp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stp_pkg::REG_LEFT_CX:  r_lcx   <= i_cfg_data[W-1:0];
                stp_pkg::REG_LEFT_CY:  r_lcy   <= i_cfg_data[W-1:0];
                stp_pkg::REG_RIGHT_CX: r_rcx   <= i_cfg_data[W-1:0];
                stp_pkg::REG_FOCAL_X:  r_focal <= i_cfg_data[stp_pkg::FOCAL_W-1:0];
                stp_pkg::REG_BASELINE: r_base  <= i_cfg_data[stp_pkg::BASE_W-1:0];
                stp_pkg::REG_GOOD:     r_good  <= i_cfg_data[stp_pkg::GOOD_W-1:0];
                stp_pkg::REG_LIMIT:    r_limit <= i_cfg_data[stp_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: disparity and offsets
    logic [W:0]   n_pos, n_negp;
    logic         r1_v, r1_flip, r1_negx, r1_negy;
    logic [W:0]   r1_d;
    logic [W-1:0] r1_magx, r1_magy;

    assign n_pos  = {1'b0, i_left_x} + {1'b0, r_rcx};
    assign n_negp = {1'b0, i_right_x} + {1'b0, r_lcx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
        r1_flip <= n_pos < n_negp;
        r1_d    <= (n_pos > n_negp) ? (n_pos - n_negp) : (W+1)'(1);
        r1_negx <= i_left_x < r_lcx;
        r1_magx <= (i_left_x < r_lcx) ? (r_lcx - i_left_x) : (i_left_x - r_lcx);
        r1_negy <= i_left_y < r_lcy;
        r1_magy <= (i_left_y < r_lcy) ? (r_lcy - i_left_y) : (i_left_y - r_lcy);
    end

    // stage 2: products with baseline
    logic              r2_v, r2_flip, r2_negx, r2_negy;
    logic [W:0]        r2_d;
    logic [PROD_W-1:0] r2_px, r2_py, r2_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_flip <= r1_flip;
        r2_negx <= r1_negx;
        r2_negy <= r1_negy;
        r2_d    <= r1_d;
        r2_px   <= PROD_W'(r1_magx) * PROD_W'(r_base);
        r2_py   <= PROD_W'(r1_magy) * PROD_W'(r_base);
        r2_pz   <= PROD_W'(r_focal) * PROD_W'(r_base);
    end

    // stage 3: rounding bias
    logic             r3_v, r3_flip, r3_negx, r3_negy;
    logic [W:0]       r3_d;
    logic [NUM_W-1:0] r3_nx, r3_ny, r3_nz, n_half;

    assign n_half = NUM_W'(r2_d >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_flip <= r2_flip;
        r3_negx <= r2_negx;
        r3_negy <= r2_negy;
        r3_d    <= r2_d;
        r3_nx   <= {1'b0, r2_px} + n_half;
        r3_ny   <= {1'b0, r2_py} + n_half;
        r3_nz   <= {1'b0, r2_pz} + n_half;
    end

    // X, Y, Z dividers
    logic             dx_v, dy_v, dz_v;
    logic [NUM_W-1:0] dx_q, dy_q, dz_q;
    logic             dx_neg, dy_neg, dz_flip;

    stp_divider #(.NUM_W(NUM_W), .DEN_W(W + 1), .Q_W(NUM_W), .SB_W(1)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v), .i_num(r3_nx),
        .i_den(r3_d), .i_sb(r3_negx), .o_valid(dx_v), .o_quot(dx_q), .o_sb(dx_neg)
    );
    stp_divider #(.NUM_W(NUM_W), .DEN_W(W + 1), .Q_W(NUM_W), .SB_W(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v), .i_num(r3_ny),
        .i_den(r3_d), .i_sb(r3_negy), .o_valid(dy_v), .o_quot(dy_q), .o_sb(dy_neg)
    );
    stp_divider #(.NUM_W(NUM_W), .DEN_W(W + 1), .Q_W(NUM_W), .SB_W(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v), .i_num(r3_nz),
        .i_den(r3_d), .i_sb(r3_flip), .o_valid(dz_v), .o_quot(dz_q), .o_sb(dz_flip)
    );

    // stage 4: saturation, near flag, scaled depth
    logic                      n_big_x, n_big_y;
    logic [stp_pkg::GOOD_W-1:0] n_g;
    logic                      r4_v, r4_flip, r4_near;
    logic [31:0]               r4_x, r4_y;
    logic [30:0]               r4_z;
    logic [Z10_W-1:0]          r4_z10;
    logic [SPAN_W-1:0]         r4_span;
    logic [stp_pkg::GOOD_W-1:0] r4_g;

    assign n_big_x = dx_q[NUM_W-1:31] != '0;
    assign n_big_y = dy_q[NUM_W-1:31] != '0;
    assign n_g     = (r_good == '0) ? stp_pkg::GOOD_W'(1) : r_good;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= dz_v && dx_v && dy_v;
        end
        r4_flip <= dz_flip;
        if (!dx_neg) begin
            r4_x <= n_big_x ? 32'h7FFF_FFFF : {1'b0, dx_q[30:0]};
        end else begin
            r4_x <= n_big_x ? 32'h8000_0000 : (32'd0 - {1'b0, dx_q[30:0]});
        end
        if (!dy_neg) begin
            r4_y <= n_big_y ? 32'h7FFF_FFFF : {1'b0, dy_q[30:0]};
        end else begin
            r4_y <= n_big_y ? 32'h8000_0000 : (32'd0 - {1'b0, dy_q[30:0]});
        end
        r4_z    <= (dz_q[NUM_W-1:31] != '0) ? 31'h7FFF_FFFF : dz_q[30:0];
        r4_near <= dz_q < NUM_W'(r_good);
        r4_z10  <= (Z10_W'(dz_q) << 3) + (Z10_W'(dz_q) << 1);
        r4_span <= (SPAN_W'(n_g) << 3) + SPAN_W'(n_g);
        r4_g    <= n_g;
    end

    // stage 5: excess over ramp start
    logic [Z10_W-1:0]  n_exc;
    logic              n_lt;
    logic              r5_v, r5_flip, r5_near, r5_lt;
    logic [31:0]       r5_x, r5_y;
    logic [30:0]       r5_z;
    logic [SPAN_W-1:0] r5_span, r5_diff;

    assign n_exc = (r4_z10 > Z10_W'(r4_g)) ? (r4_z10 - Z10_W'(r4_g)) : '0;
    assign n_lt  = n_exc < Z10_W'(r4_span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_flip <= r4_flip;
        r5_near <= r4_near;
        r5_x    <= r4_x;
        r5_y    <= r4_y;
        r5_z    <= r4_z;
        r5_lt   <= n_lt;
        r5_span <= r4_span;
        r5_diff <= n_lt ? (r4_span - n_exc[SPAN_W-1:0]) : '0;
    end

    // stage 6: scaled threshold numerator
    logic                       r6_v;
    logic [stp_pkg::TNUM_W-1:0] r6_num;
    logic [SPAN_W-1:0]          r6_span;
    logic [TSB_W-1:0]           r6_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_num  <= stp_pkg::TNUM_W'(r_limit) * stp_pkg::TNUM_W'(r5_diff);
        r6_span <= r5_span;
        r6_sb   <= {r5_x, r5_y, r5_z, r5_near, r5_flip, r5_lt};
    end

    logic                        dt_v;
    logic [stp_pkg::LIMIT_W-1:0] dt_q;
    logic [TSB_W-1:0]            dt_sb;

    stp_divider #(
        .NUM_W(stp_pkg::TNUM_W), .DEN_W(SPAN_W), .Q_W(stp_pkg::LIMIT_W), .SB_W(TSB_W)
    ) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r6_v), .i_num(r6_num),
        .i_den(r6_span), .i_sb(r6_sb), .o_valid(dt_v), .o_quot(dt_q), .o_sb(dt_sb)
    );

    // stage 7: output beat
    logic [stp_pkg::LIMIT_W-1:0] n_thr;
    logic                        r_strobe;

    assign n_thr = (dt_sb[0] && (dt_q > stp_pkg::ONE_PIXEL)) ? dt_q : stp_pkg::ONE_PIXEL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dt_v;
        end
        o_point_x       <= dt_sb[97:66];
        o_point_y       <= dt_sb[65:34];
        o_point_z       <= dt_sb[33:3];
        o_near_point    <= dt_sb[2];
        o_flipped       <= dt_sb[1];
        o_limit_squared <= 32'(n_thr) * 32'(n_thr);
    end

    assign o_strobe = r_strobe;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("beat after reset");
    a_min_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_limit_squared >= 32'h0001_0000)
        else $error("inlier limit below one pixel");
    a_near_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_near_point |-> o_point_z < r_good)
        else $error("near point at or beyond good depth");
`endif

endmodule

### sv/stp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires (num >> Q_W) < den. The inputs are registered before the first stage.
// ----------------------------------------------------------------------------
module stp_divider #(
    parameter int NUM_W = stp_pkg::TNUM_W,
    parameter int DEN_W = stp_pkg::SPAN_W,
    parameter int Q_W   = stp_pkg::LIMIT_W,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot,
    output logic [SB_W-1:0]  o_sb
);

    localparam int R_W = DEN_W + 1;

    logic [R_W-1:0]   r_rem [0:Q_W];
    logic [Q_W-1:0]   r_lq  [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [SB_W-1:0]  r_sb  [0:Q_W];
    logic             r_v   [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= R_W'(i_num >> Q_W);
        r_lq[0]  <= i_num[Q_W-1:0];
        r_den[0] <= i_den;
        r_sb[0]  <= i_sb;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [R_W-1:0] n_trial;
        logic           n_ge;
        logic [R_W-1:0] n_rem;

        assign n_trial = {r_rem[k][R_W-2:0], r_lq[k][Q_W-1]};
        assign n_ge    = n_trial >= {1'b0, r_den[k]};
        assign n_rem   = n_ge ? (n_trial - {1'b0, r_den[k]}) : n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rem[k+1] <= n_rem;
            r_lq[k+1]  <= {r_lq[k][Q_W-2:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_sb[k+1]  <= r_sb[k];
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_quot  = r_lq[Q_W];
    assign o_sb    = r_sb[Q_W];

endmodule
